FILE: src/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the compacting list table: command and
// status codes, the sequencer state type and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

    // default storage depth and capacity register reset value
    localparam int          DEFAULT_LIST_DEPTH = 256;
    localparam int          CAP_W              = 9;
    localparam logic [8:0]  CAP_RESET          = 9'd256;

    // field widths fixed by the interface
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int CNT_W  = 9;

    // command codes
    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_READ   = 3'd3,
        CMD_COUNT  = 3'd4
    } t_cmd;

    // status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_READ_WAIT,
        SEQ_SHIFT,
        SEQ_SCAN,
        SEQ_RESULT
    } t_seq_state;

    // one result transaction from the sequencer
    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  match_count;
        logic [CNT_W-1:0]  entries_now;
        t_status           status;
    } t_result;

endpackage

`default_nettype wire

FILE: src/clt_mem.sv
// ----------------------------------------------------------------------------
// clt_mem
// Entry storage: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_mem
    import clt_pkg::*;
#(
    parameter int DEPTH = DEFAULT_LIST_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/clt_seq.sv
// ----------------------------------------------------------------------------
// clt_seq
// Command sequencer: holds the entry count, decodes one command at a time,
// drives the storage ports for append, edit, read, the remove shift-down
// and the count scan, and hands one result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_seq
    import clt_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int AW         = $clog2(LIST_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command transaction
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [2:0]        i_command,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [DATA_W-1:0] i_operand,
    // capacity register
    input  wire logic [CAP_W-1:0]  i_cap,
    // storage ports
    output logic                   o_we,
    output logic      [AW-1:0]     o_waddr,
    output logic      [DATA_W-1:0] o_wdata,
    output logic                   o_re,
    output logic      [AW-1:0]     o_raddr,
    input  wire logic [DATA_W-1:0] i_rdata,
    // result transaction
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    t_seq_state        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [2:0]        r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_rd, n_rd;
    logic [CW-1:0]     r_match, n_match;
    t_status           r_status, n_status;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_wa, n_wa;
    logic              r_pend, n_pend;

    logic              in_range;
    logic              list_full;
    logic [31:0]       lim;
    logic              issue;
    logic              accept;

    // limit in force and range checks
    always_comb begin
        lim       = (32'(i_cap) > LIST_DEPTH) ? 32'(LIST_DEPTH) : 32'(i_cap);
        list_full = 32'(r_count) >= lim;
        in_range  = (32'(r_pos) < 32'(r_count)) && (32'(r_pos) < LIST_DEPTH);
        issue     = r_idx < r_count;
        accept    = i_in_valid && !o_in_stall;
    end

    assign o_in_stall  = (r_state != SEQ_IDLE);
    assign o_res_valid = (r_state == SEQ_RESULT);

    // result bundle
    always_comb begin
        o_res.read_value  = r_rd;
        o_res.match_count = CNT_W'(r_match);
        o_res.entries_now = CNT_W'(r_count);
        o_res.status      = r_status;
    end

    // next state and storage control
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd     = r_rd;
        n_match  = r_match;
        n_status = r_status;
        n_idx    = r_idx;
        n_wa     = r_wa;
        n_pend   = 1'b0;
        o_we     = 1'b0;
        o_waddr  = AW'(r_count);
        o_wdata  = r_val;
        o_re     = 1'b0;
        o_raddr  = AW'(r_pos);

        case (r_state)
            SEQ_IDLE: begin
                if (accept) begin
                    n_state  = SEQ_EXEC;
                    n_rd     = '0;
                    n_match  = '0;
                    n_status = ST_DONE;
                end
            end

            SEQ_EXEC: begin
                n_state = SEQ_RESULT;
                case (r_cmd)
                    CMD_APPEND: begin
                        if (list_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = AW'(r_count);
                            n_count = r_count + 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!in_range) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_state = SEQ_SHIFT;
                            n_idx   = CW'(r_pos) + 1'b1;
                            n_wa    = CW'(r_pos);
                        end
                    end
                    CMD_EDIT: begin
                        if (!in_range) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = AW'(r_pos);
                        end
                    end
                    CMD_READ: begin
                        if (!in_range) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = AW'(r_pos);
                            n_state = SEQ_READ_WAIT;
                        end
                    end
                    CMD_COUNT: begin
                        n_state = SEQ_SCAN;
                        n_idx   = '0;
                    end
                    default: begin
                        n_state = SEQ_RESULT;
                    end
                endcase
            end

            SEQ_READ_WAIT: begin
                n_rd    = i_rdata;
                n_state = SEQ_RESULT;
            end

            // read entry idx, write it one place down in the cycle after
            SEQ_SHIFT: begin
                if (issue) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_idx);
                    n_idx   = r_idx + 1'b1;
                    n_pend  = 1'b1;
                end
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_wa);
                    o_wdata = i_rdata;
                    n_wa    = r_wa + 1'b1;
                end
                if (!issue && !r_pend) begin
                    n_count = r_count - 1'b1;
                    n_state = SEQ_RESULT;
                end
            end

            // stream every held entry through the compare
            SEQ_SCAN: begin
                if (issue) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_idx);
                    n_idx   = r_idx + 1'b1;
                    n_pend  = 1'b1;
                end
                if (r_pend && (i_rdata == r_val)) begin
                    n_match = r_match + 1'b1;
                end
                if (!issue && !r_pend) begin
                    n_state = SEQ_RESULT;
                end
            end

            SEQ_RESULT: begin
                if (i_res_ready) begin
                    n_state = SEQ_IDLE;
                end
            end

            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_pos <= i_position;
            r_val <= i_operand;
        end
        r_rd     <= n_rd;
        r_match  <= n_match;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_wa     <= n_wa;
    end

    // entry count never exceeds the storage depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= LIST_DEPTH)
        else $error("entry count above storage depth");

    // storage is never written while waiting for a command
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_IDLE) |-> !o_we)
        else $error("storage write while idle");

    // shift-down never reads and writes the same entry in one cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && o_re) |-> (o_waddr != o_raddr))
        else $error("read and write of the same entry");

    // a completed remove drops the count by exactly one
    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_SHIFT && n_state == SEQ_RESULT) |=>
            (r_count == $past(r_count) - 1'b1))
        else $error("remove did not decrement count");

endmodule

`default_nettype wire

FILE: src/compacting_list_table_core.sv
// Append, edit, rejected and unknown commands go from execution straight to the result; an
// in-range read waits for the registered read data; remove shifts the later entries down and
// count scans every held entry. One command at a time: the block is ready for the next in the
// cycle after the result moves to the output register; remove and count pass one entry per
// cycle through the memory port. Reset (synchronous, active low) empties the list and sets the
// capacity limit to 256; entries are not cleared.
// ----------------------------------------------------------------------------
// compacting_list_table_core
// Packed list of signed 32-bit entries with append, remove with compaction,
// edit, read and count-equal commands, over a single-port-pair memory.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_list_table_core
    import clt_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // command channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [2:0]               i_command,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_operand_value,
    // result channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic [CNT_W-1:0]              o_match_count,
    output logic [CNT_W-1:0]              o_entries_now,
    output logic [1:0]                    o_status,
    // configuration channel
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CAP_W-1:0]         i_cfg_data
);

    localparam int AW = $clog2(LIST_DEPTH);

    logic [CAP_W-1:0]  r_cap;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;

    // capacity register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    clt_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    clt_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_operand   (i_operand_value),
        .i_cap       (r_cap),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register: takes a result when empty or being drained
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = $signed(r_out.read_value);
    assign o_match_count = r_out.match_count;
    assign o_entries_now = r_out.entries_now;
    assign o_status      = r_out.status;

endmodule

`default_nettype wire

FILE: tb/compacting_list_table_core_test.sv
// ----------------------------------------------------------------------------
// compacting_list_table_core_test
// Self-checking bench for the compacting list table. It drives list commands
// under random gaps and output stalls and keeps a shadow copy of the list
// and its capacity. Each result transaction is checked field by field
// against the shadow in command order.
// ----------------------------------------------------------------------------

module compacting_list_table_core_test
    import clt_pkg::*;
();

    localparam int LIST_DEPTH  = DEFAULT_LIST_DEPTH;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 300;

    // command codes the block does not decode
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    // dut stimulus, known from time zero
    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic [2:0]               i_command       = '0;
    logic [POS_W-1:0]         i_position      = '0;
    logic signed [DATA_W-1:0] i_operand_value = '0;
    logic                     i_out_stall     = 1'b0;
    logic                     i_cfg_valid     = 1'b0;
    logic [CAP_W-1:0]         i_cfg_data      = '0;

    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_read_value;
    logic [CNT_W-1:0]         o_match_count;
    logic [CNT_W-1:0]         o_entries_now;
    logic [1:0]               o_status;
    logic                     o_cfg_ready;

    // shadow of the list state
    logic [DATA_W-1:0] shadow_list [LIST_DEPTH];
    int unsigned       shadow_count    = 0;
    logic [CAP_W-1:0]  shadow_capacity = CAP_RESET;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      cycle_count    = 0;

    compacting_list_table_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_value    (o_read_value),
        .o_match_count   (o_match_count),
        .o_entries_now   (o_entries_now),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // apply one command to the shadow list and return the result it produces
    function automatic t_result apply_list_command(input logic [2:0] cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        t_result     res;
        int unsigned lim;
        bit          in_range;
        int unsigned i;
        res        = '0;
        res.status = ST_DONE;
        lim        = (shadow_capacity > LIST_DEPTH) ? LIST_DEPTH : shadow_capacity;
        in_range   = (pos < shadow_count);
        case (cmd)
            CMD_APPEND: begin
                if (shadow_count >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_list[shadow_count] = val;
                    shadow_count++;
                end
            end
            CMD_REMOVE: begin
                if (!in_range) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                end
            end
            CMD_EDIT: begin
                if (!in_range)
                    res.status = ST_RANGE;
                else
                    shadow_list[pos] = val;
            end
            CMD_READ: begin
                if (!in_range)
                    res.status = ST_RANGE;
                else
                    res.read_value = shadow_list[pos];
            end
            CMD_COUNT: begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_list[i] == val)
                        res.match_count++;
            end
            default: begin
            end
        endcase
        res.entries_now = CNT_W'(shadow_count);
        return res;
    endfunction

    // operand: full random, a small pool, extremes, or a value already held
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = DATA_W'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            default: begin
                if (shadow_count > 0)
                    v = shadow_list[$urandom_range(0, shadow_count - 1)];
                else
                    v = $urandom;
            end
        endcase
        return v;
    endfunction

    // position: mostly inside the held range, sometimes anywhere
    function automatic logic [POS_W-1:0] pick_position();
        if (shadow_count > 0 && $urandom_range(0, 99) < 80)
            return POS_W'($urandom_range(0, shadow_count - 1));
        return POS_W'($urandom_range(0, 255));
    endfunction

    // send one command transaction and record what it should return
    task automatic send_command(input logic [2:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_position      <= pos;
        i_operand_value <= val;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_results.push_back(apply_list_command(cmd, pos, val));
    endtask

    task automatic send_random_command(input int append_pct);
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < append_pct) begin
            cmd = CMD_APPEND;
        end else if (r >= 97) begin
            cmd = CMD_SPARE_A + 3'($urandom_range(0, 2));
        end else begin
            case ($urandom_range(0, 3))
                0: cmd = CMD_REMOVE;
                1: cmd = CMD_EDIT;
                2: cmd = CMD_READ;
                default: cmd = CMD_COUNT;
            endcase
        end
        send_command(cmd, pick_position(), pick_operand());
    endtask

    // hold off new commands until every result is back
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // capacity write, only with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_all_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid     <= 1'b0;
        shadow_capacity  = cap;
    endtask

    // result check and receiver stall
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with no command outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %h want %h",
                                              o_read_value, want.read_value));
                if (o_match_count !== want.match_count)
                    report_mismatch($sformatf("match_count got %0d want %0d",
                                              o_match_count, want.match_count));
                if (o_entries_now !== want.entries_now)
                    report_mismatch($sformatf("entries_now got %0d want %0d",
                                              o_entries_now, want.entries_now));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // field extremes, every command, range errors and unknown codes
    task automatic test_directed_extremes();
        send_command(CMD_READ, 8'd0, 32'h0);
        send_command(CMD_REMOVE, 8'd255, 32'hFFFF_FFFF);
        send_command(CMD_EDIT, 8'd0, 32'h1);
        send_command(CMD_COUNT, 8'd0, 32'h0);
        send_command(CMD_APPEND, 8'd0, 32'h8000_0000);
        send_command(CMD_APPEND, 8'd255, 32'h7FFF_FFFF);
        send_command(CMD_APPEND, 8'd0, 32'h0000_0000);
        send_command(CMD_APPEND, 8'd0, 32'hFFFF_FFFF);
        send_command(CMD_APPEND, 8'd0, 32'h5555_5555);
        send_command(CMD_APPEND, 8'd0, 32'hAAAA_AAAA);
        send_command(CMD_READ, 8'd0, 32'h0);
        send_command(CMD_READ, 8'd5, 32'h0);
        send_command(CMD_READ, 8'd6, 32'h0);
        send_command(CMD_READ, 8'd255, 32'h0);
        send_command(CMD_COUNT, 8'd0, 32'hFFFF_FFFF);
        send_command(CMD_EDIT, 8'd2, 32'hFFFF_FFFF);
        send_command(CMD_COUNT, 8'd0, 32'hFFFF_FFFF);
        // remove at head, at tail and in the middle
        send_command(CMD_REMOVE, 8'd0, 32'h0);
        send_command(CMD_REMOVE, 8'd4, 32'h0);
        send_command(CMD_REMOVE, 8'd1, 32'h0);
        send_command(CMD_READ, 8'd1, 32'h0);
        send_command(CMD_SPARE_A, 8'd0, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_B, 8'd255, 32'h0);
        send_command(CMD_SPARE_C, 8'd1, 32'h8000_0000);
    endtask

    // zero capacity rejects every append, capacity one holds a single entry
    task automatic test_small_capacity();
        write_capacity(9'd0);
        send_command(CMD_APPEND, 8'd0, pick_operand());
        send_command(CMD_COUNT, 8'd0, pick_operand());
        repeat (3) send_command(CMD_REMOVE, 8'd0, 32'h0);
        send_command(CMD_APPEND, 8'd0, pick_operand());
        write_capacity(9'd1);
        send_command(CMD_APPEND, 8'd0, pick_operand());
        send_command(CMD_APPEND, 8'd0, pick_operand());
        send_command(CMD_READ, 8'd0, 32'h0);
        send_command(CMD_EDIT, 8'd0, pick_operand());
        send_command(CMD_REMOVE, 8'd0, 32'h0);
        send_command(CMD_APPEND, 8'd0, pick_operand());
        send_command(CMD_APPEND, 8'd0, pick_operand());
        repeat (12) send_random_command(40);
    endtask

    // limit dropped below the held count, then removes reopen appends
    task automatic test_capacity_lowered();
        write_capacity(9'd300);
        repeat (12) send_command(CMD_APPEND, pick_position(), pick_operand());
        write_capacity(9'd4);
        repeat (30) send_random_command(40);
    endtask

    // fill the whole store, then long shifts and scans over it
    task automatic test_fill_to_depth();
        write_capacity(9'd511);
        while (shadow_count < LIST_DEPTH)
            send_random_command(90);
        send_command(CMD_APPEND, 8'd0, pick_operand());
        send_command(CMD_COUNT, 8'd0, pick_operand());
        send_command(CMD_READ, 8'd255, 32'h0);
        send_command(CMD_REMOVE, 8'd0, 32'h0);
        send_command(CMD_READ, 8'd255, 32'h0);
        send_command(CMD_EDIT, 8'd254, pick_operand());
        repeat (30) send_random_command(10);
    endtask

    // mixed traffic at a small capacity, a full drain, then any capacity
    task automatic test_mixed_traffic(input int n_items);
        write_capacity(CAP_W'($urandom_range(2, 40)));
        repeat (n_items / 2) send_random_command(40);
        wait_all_results();
        write_capacity(CAP_W'($urandom_range(1, 511)));
        repeat (n_items - n_items / 2) send_random_command(40);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 86;
        test_directed_extremes();
        test_small_capacity();
        test_capacity_lowered();

        send_idle_pct = 86;
        recv_idle_pct = 30;
        test_fill_to_depth();
        test_mixed_traffic(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mixed_traffic(130);

        // let any stray result show up before the verdict
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/clt_pkg.sv
src/clt_mem.sv
src/clt_seq.sv
src/compacting_list_table_core.sv
tb/compacting_list_table_core_test.sv
